FILE: hdl/hec_pkg.sv
// Shared types, constants and table functions for the horizon/equatorial converter.
package hec_pkg;

	// Internal phase width (full turn = 2^32) and vector component width (Q30 plus growth)
	localparam int PW = 32;
	localparam int VW = 34;

	localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
	localparam logic signed [VW-1:0] ONE_Q30 = VW'(64'sd1 <<< 30);
	localparam logic signed [VW-1:0] PH_QUARTER = VW'(64'sd1 <<< 30);
	localparam logic signed [VW-1:0] PH_HALF = VW'(64'sd1 <<< 31);

	typedef struct packed {
		logic signed [VW-1:0] a;
		logic signed [VW-1:0] b;
		logic signed [VW-1:0] r;
	} vec_t;

	// Items carried next to each CORDIC pass
	typedef struct packed {
		logic          func;
		logic [PW-1:0] lon;
		logic [PW-1:0] lst;
	} side0_t;

	typedef struct packed {
		logic                 func;
		logic [PW-1:0]        lst;
		logic signed [VW-1:0] c;
	} side1_t;

	typedef struct packed {
		logic                 func;
		logic signed [VW-1:0] c;
	} side3_t;

	typedef struct packed {
		logic                 func;
		logic                 pole;
		logic signed [VW-1:0] z;
	} side4_t;

	typedef struct packed {
		logic          func;
		logic          pole_lon;
		logic          pole_lat;
		logic [PW-1:0] plon;
	} side5_t;

	// Unsigned 64-bit quotient by shift and subtract, used only to build constants
	function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
		logic [63:0] quo;
		logic [64:0] rem;
		int i;
		quo = '0;
		rem = '0;
		for (i = 63; i >= 0; i--) begin
			rem = {rem[63:0], n[i]};
			if (rem >= {1'b0, d}) begin
				rem = rem - {1'b0, d};
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	// Arctangent of 2^-i as a phase, full turn = 2^32
	function automatic logic [PW-1:0] atan_entry(input int i);
		longint sum;
		logic [63:0] term;
		int k;
		if (i == 0) begin
			return PW'(64'd1 << 29);
		end
		sum = 0;
		for (k = 0; k < 32; k++) begin
			if (i * (2 * k + 1) <= 62) begin
				term = udiv64(64'd1 << (62 - i * (2 * k + 1)), 64'(2 * k + 1));
				sum = k[0] ? sum - longint'(term) : sum + longint'(term);
			end
		end
		return PW'(udiv64(64'(sum) + (TWO_PI_Q30 >> 1), TWO_PI_Q30));
	endfunction

	// Inverse CORDIC gain in Q31 for n stages
	function automatic logic [PW-1:0] inv_gain(input int n);
		logic [63:0] q;
		logic [63:0] res;
		logic [63:0] bt;
		int i;
		q = 64'd1 << 62;
		for (i = 0; i < 32; i++) begin
			if (i < n) begin
				q = q - udiv64(q, (64'd1 << (2 * i)) + 64'd1);
			end
		end
		res = 64'd0;
		bt = 64'd1 << 62;
		for (i = 0; i < 32; i++) begin
			if (bt > q) begin
				bt = bt >> 2;
			end
		end
		for (i = 0; i < 32; i++) begin
			if (bt != 64'd0) begin
				if (q >= res + bt) begin
					q = q - (res + bt);
					res = (res >> 1) + bt;
				end else begin
					res = res >> 1;
				end
				bt = bt >> 2;
			end
		end
		return PW'(res);
	endfunction

endpackage

FILE: hdl/hec_if.sv
// Channel interfaces: direction items in, converted items out, latitude writes.
interface hec_req_if #(parameter int ANGLE_BITS = 24);
	logic                         valid;
	logic                         ready;
	logic                         func;
	logic [ANGLE_BITS-1:0]        angle_lon;
	logic signed [ANGLE_BITS-1:0] angle_lat;
	logic [ANGLE_BITS-1:0]        sidereal_time;
	modport source(output valid, func, angle_lon, angle_lat, sidereal_time, input ready);
	modport sink(input valid, func, angle_lon, angle_lat, sidereal_time, output ready);
endinterface

interface hec_rsp_if #(parameter int ANGLE_BITS = 24);
	logic                         valid;
	logic                         ready;
	logic [ANGLE_BITS-1:0]        out_lon;
	logic signed [ANGLE_BITS-1:0] out_lat;
	modport source(output valid, out_lon, out_lat, input ready);
	modport sink(input valid, out_lon, out_lat, output ready);
endinterface

interface hec_cfg_if #(parameter int ANGLE_BITS = 24);
	logic                         valid;
	logic                         ready;
	logic signed [ANGLE_BITS-1:0] data;
	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

FILE: hdl/horizon_equatorial_conversion_core.sv
// Top level: horizon <-> equatorial direction converter built from CORDIC cell chains.
//
//  channel  role    handshake     payload
//  req      input   valid/ready   func, angle_lon, angle_lat, sidereal_time
//  rsp      output  valid/ready   out_lon, out_lat
//  cfg      input   valid/ready   data (site latitude)
//
// One item per cycle is accepted while the result is not stalled; the pipeline is
// six CORDIC passes of one quadrant stage, CORDIC_STAGES cells and a gain stage,
// plus the output register. Reset clears the valid bits and the site latitude.
// All stages advance together; a stalled result holds the whole pipeline.
module horizon_equatorial_conversion_core #(
	parameter int ANGLE_BITS    = 24,
	parameter int CORDIC_STAGES = 24
) (
	input logic   clk,
	input logic   arst_n,
	hec_req_if.sink req,
	hec_rsp_if.source rsp,
	hec_cfg_if.sink cfg
);
	import hec_pkg::*;

	localparam int SH = PW - ANGLE_BITS;
	localparam logic [PW:0] RND = (33'd1 << SH) >> 1;
	localparam logic signed [VW-1:0] LIM = VW'(64'sd1 <<< (ANGLE_BITS - 2));

	logic en;
	logic [ANGLE_BITS-1:0] site_q;
	logic [PW-1:0] lon_ph, lat_ph, lst_ph, site_ph;

	logic v0, v1, v2, v3, v4, v5;
	logic signed [VW-1:0] a0, b0, a1, b1, a2, b2, a3, b3, a4, r4, r5;
	logic signed [VW-1:0] b4_unused, r0_unused, r1_unused, r2_unused, r3_unused;
	logic signed [VW-1:0] a5_unused, b5_unused;
	side0_t s0_in, s0;
	side1_t s1_in, s1, s2_in, s2;
	side3_t s3_in, s3;
	side4_t s4_in, s4;
	side5_t s5_in, s5;

	logic signed [VW-1:0] u2_a, u2_b, u3_a, u3_b;
	logic signed [VW-1:0] x1, y1, z1, x2, y2, z2, x3, y3, z3;
	logic [PW-1:0] u1_r, u2_r, u3_r;

	logic [PW-1:0] plon, plat;
	logic [PW:0] olon;
	logic signed [VW-1:0] vr, vs, vc;

	logic valid_q;
	logic [ANGLE_BITS-1:0] lon_q;
	logic [ANGLE_BITS-1:0] lat_q;

	assign en = !valid_q || rsp.ready;
	assign req.ready = en;
	assign cfg.ready = 1'b1;

	// site latitude register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			site_q <= '0;
		end else if (cfg.valid) begin
			site_q <= cfg.data;
		end
	end

	// binary angles to 32-bit phases
	always_comb begin
		lon_ph = PW'(req.angle_lon) << SH;
		lat_ph = PW'(req.angle_lat) << SH;
		lst_ph = PW'(req.sidereal_time) << SH;
		site_ph = PW'(site_q) << SH;
		s0_in.func = req.func;
		s0_in.lon = lon_ph;
		s0_in.lst = lst_ph;
	end

	// pass 0: tilt unit x by the latitude angle into (x, z)
	hec_rot_unit #(.STAGES(CORDIC_STAGES), .VECT(1'b0), .SIDE_W($bits(side0_t))) u_p0 (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(req.valid),
		.in_a(ONE_Q30), .in_b('0), .in_r(lat_ph), .in_side(s0_in),
		.out_valid(v0), .out_a(a0), .out_b(b0), .out_r(r0_unused), .out_side(s0)
	);

	// pass 1: rotate about z by the longitude
	always_comb begin
		s1_in.func = s0.func;
		s1_in.lst = s0.lst;
		s1_in.c = b0;
		u1_r = s0.func ? s0.lon : PW'(0) - s0.lon;
	end

	hec_rot_unit #(.STAGES(CORDIC_STAGES), .VECT(1'b0), .SIDE_W($bits(side1_t))) u_p1 (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v0),
		.in_a(a0), .in_b('0), .in_r(u1_r), .in_side(s1_in),
		.out_valid(v1), .out_a(a1), .out_b(b1), .out_r(r1_unused), .out_side(s1)
	);

	// pass 2: colatitude tilt (to equatorial) or sidereal spin (to horizon)
	always_comb begin
		x1 = a1;
		y1 = b1;
		z1 = s1.c;
		s2_in.func = s1.func;
		s2_in.lst = s1.lst;
		if (!s1.func) begin
			u2_a = z1;
			u2_b = x1;
			u2_r = PW'(PH_QUARTER) - site_ph;
			s2_in.c = y1;
		end else begin
			u2_a = x1;
			u2_b = y1;
			u2_r = PW'(0) - s1.lst;
			s2_in.c = z1;
		end
	end

	hec_rot_unit #(.STAGES(CORDIC_STAGES), .VECT(1'b0), .SIDE_W($bits(side1_t))) u_p2 (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v1),
		.in_a(u2_a), .in_b(u2_b), .in_r(u2_r), .in_side(s2_in),
		.out_valid(v2), .out_a(a2), .out_b(b2), .out_r(r2_unused), .out_side(s2)
	);

	// pass 3: sidereal spin (to equatorial) or colatitude tilt (to horizon)
	always_comb begin
		if (!s2.func) begin
			z2 = a2;
			x2 = b2;
			y2 = s2.c;
			u3_a = x2;
			u3_b = y2;
			u3_r = s2.lst;
			s3_in.c = z2;
		end else begin
			x2 = a2;
			y2 = b2;
			z2 = s2.c;
			u3_a = z2;
			u3_b = x2;
			u3_r = site_ph - PW'(PH_QUARTER);
			s3_in.c = y2;
		end
		s3_in.func = s2.func;
	end

	hec_rot_unit #(.STAGES(CORDIC_STAGES), .VECT(1'b0), .SIDE_W($bits(side3_t))) u_p3 (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v2),
		.in_a(u3_a), .in_b(u3_b), .in_r(u3_r), .in_side(s3_in),
		.out_valid(v3), .out_a(a3), .out_b(b3), .out_r(r3_unused), .out_side(s3)
	);

	// pass 4: longitude and equatorial radius from (x, y)
	always_comb begin
		if (!s3.func) begin
			x3 = a3;
			y3 = b3;
			z3 = s3.c;
		end else begin
			z3 = a3;
			x3 = b3;
			y3 = s3.c;
		end
		s4_in.func = s3.func;
		s4_in.pole = (x3 == '0) && (y3 == '0);
		s4_in.z = z3;
	end

	hec_rot_unit #(.STAGES(CORDIC_STAGES), .VECT(1'b1), .SIDE_W($bits(side4_t))) u_p4 (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v3),
		.in_a(x3), .in_b(y3), .in_r('0), .in_side(s4_in),
		.out_valid(v4), .out_a(a4), .out_b(b4_unused), .out_r(r4), .out_side(s4)
	);

	// pass 5: latitude from (radius, z)
	always_comb begin
		s5_in.func = s4.func;
		s5_in.pole_lon = s4.pole;
		s5_in.pole_lat = (a4 == '0) && (s4.z == '0);
		s5_in.plon = PW'(r4);
	end

	hec_rot_unit #(.STAGES(CORDIC_STAGES), .VECT(1'b1), .SIDE_W($bits(side5_t))) u_p5 (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v4),
		.in_a(a4), .in_b(s4.z), .in_r('0), .in_side(s5_in),
		.out_valid(v5), .out_a(a5_unused), .out_b(b5_unused), .out_r(r5), .out_side(s5)
	);

	// round to output angle width, clamp latitude to a quarter turn
	always_comb begin
		plon = s5.pole_lon ? '0 : s5.plon;
		if (s5.func) begin
			plon = PW'(0) - plon;
		end
		plat = s5.pole_lat ? '0 : PW'(r5);
		olon = ({1'b0, plon} + RND) >> SH;
		vr = $signed({{(VW-PW){plat[PW-1]}}, plat}) + $signed({{(VW-PW-1){1'b0}}, RND});
		vs = vr >>> SH;
		vc = vs;
		if (vs > LIM) begin
			vc = LIM;
		end else if (vs < -LIM) begin
			vc = -LIM;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= v5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lon_q <= ANGLE_BITS'(olon);
			lat_q <= ANGLE_BITS'(vc);
		end
	end

	assign rsp.valid = valid_q;
	assign rsp.out_lon = lon_q;
	assign rsp.out_lat = lat_q;

`ifndef SYNTHESIS
	// a held result blocks new items
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !rsp.ready) |-> !req.ready)
		else $error("item accepted while result stalled");

	// latitude result stays within a quarter turn
	a_lat_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> ($signed({lat_q[ANGLE_BITS-1], lat_q}) <= $signed(LIM[ANGLE_BITS:0]))
		&& ($signed({lat_q[ANGLE_BITS-1], lat_q}) >= -$signed(LIM[ANGLE_BITS:0])))
		else $error("latitude out of range");

	// an accepted item enters the first pass
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> u_p0.valid_s1)
		else $error("accepted item lost at entry");
`endif
endmodule

FILE: hdl/hec_cordic_cell.sv
// One CORDIC micro-rotation cell with its stage register.
module hec_cordic_cell #(
	parameter int IDX    = 0,
	parameter bit VECT   = 1'b0,
	parameter int SIDE_W = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  hec_pkg::vec_t       in_v,
	input  logic [SIDE_W-1:0]   in_side,
	output logic                out_valid,
	output hec_pkg::vec_t       out_v,
	output logic [SIDE_W-1:0]   out_side
);
	import hec_pkg::*;

	localparam logic [PW-1:0] ATAN = atan_entry(IDX);

	logic                 up;
	logic signed [VW-1:0] da;
	logic signed [VW-1:0] db;
	logic signed [VW-1:0] dr;
	vec_t                 nxt;
	logic                 valid_s1;
	vec_t                 vec_s1;
	logic [SIDE_W-1:0]    side_s1;

	// direction: residual sign when rotating, y sign when vectoring
	always_comb begin
		up = VECT ? (in_v.b < 0) : (in_v.r >= 0);
		da = in_v.b >>> IDX;
		db = in_v.a >>> IDX;
		dr = $signed({{(VW-PW){1'b0}}, ATAN});
		if (up) begin
			nxt.a = in_v.a - da;
			nxt.b = in_v.b + db;
			nxt.r = in_v.r - dr;
		end else begin
			nxt.a = in_v.a + da;
			nxt.b = in_v.b - db;
			nxt.r = in_v.r + dr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vec_s1 <= nxt;
			side_s1 <= in_side;
		end
	end

	assign out_valid = valid_s1;
	assign out_v = vec_s1;
	assign out_side = side_s1;
endmodule

FILE: hdl/hec_rot_unit.sv
// One CORDIC pass: quadrant stage, a chain of cells, gain compensation stage.
module hec_rot_unit #(
	parameter int STAGES = 24,
	parameter bit VECT   = 1'b0,
	parameter int SIDE_W = 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic signed [hec_pkg::VW-1:0] in_a,
	input  logic signed [hec_pkg::VW-1:0] in_b,
	input  logic [hec_pkg::PW-1:0]       in_r,
	input  logic [SIDE_W-1:0]            in_side,
	output logic                         out_valid,
	output logic signed [hec_pkg::VW-1:0] out_a,
	output logic signed [hec_pkg::VW-1:0] out_b,
	output logic signed [hec_pkg::VW-1:0] out_r,
	output logic [SIDE_W-1:0]            out_side
);
	import hec_pkg::*;

	localparam logic [PW-1:0] GAIN = inv_gain(STAGES);
	localparam logic signed [2*VW-1:0] GRND = (2*VW)'(64'sd1 <<< 30);

	vec_t              pre;
	logic              valid_s1;
	vec_t              vec_s1;
	logic [SIDE_W-1:0] side_s1;

	vec_t              cv [0:STAGES];
	logic              cvl [0:STAGES];
	logic [SIDE_W-1:0] csd [0:STAGES];

	logic signed [2*VW-1:0] pa;
	logic signed [2*VW-1:0] pb;
	logic                   valid_s2;
	logic signed [VW-1:0]   a_s2;
	logic signed [VW-1:0]   b_s2;
	logic signed [VW-1:0]   r_s2;
	logic [SIDE_W-1:0]      side_s2;

	// fold into the right half plane / within a quarter turn
	always_comb begin
		pre.a = in_a;
		pre.b = in_b;
		if (VECT) begin
			pre.r = '0;
			if (in_a < 0) begin
				pre.a = -in_a;
				pre.b = -in_b;
				pre.r = PH_HALF;
			end
		end else begin
			pre.r = VW'($signed(in_r));
			if (pre.r > PH_QUARTER) begin
				pre.a = -in_a;
				pre.b = -in_b;
				pre.r = pre.r - PH_HALF;
			end else if (pre.r < -PH_QUARTER) begin
				pre.a = -in_a;
				pre.b = -in_b;
				pre.r = pre.r + PH_HALF;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= cvl[STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vec_s1 <= pre;
			side_s1 <= in_side;
		end
	end

	assign cv[0] = vec_s1;
	assign cvl[0] = valid_s1;
	assign csd[0] = side_s1;

	// chain of micro-rotation cells
	for (genvar g = 0; g < STAGES; g++) begin : g_cell
		hec_cordic_cell #(
			.IDX   (g),
			.VECT  (VECT),
			.SIDE_W(SIDE_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (cvl[g]),
			.in_v     (cv[g]),
			.in_side  (csd[g]),
			.out_valid(cvl[g+1]),
			.out_v    (cv[g+1]),
			.out_side (csd[g+1])
		);
	end

	// gain compensation, round half up at bit 31
	always_comb begin
		pa = (2*VW)'(cv[STAGES].a) * $signed({{(VW-PW){1'b0}}, GAIN}) + GRND;
		pb = (2*VW)'(cv[STAGES].b) * $signed({{(VW-PW){1'b0}}, GAIN}) + GRND;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s2 <= VW'(pa >>> 31);
			b_s2 <= VW'(pb >>> 31);
			r_s2 <= cv[STAGES].r;
			side_s2 <= csd[STAGES];
		end
	end

	assign out_valid = valid_s2;
	assign out_a = a_s2;
	assign out_b = b_s2;
	assign out_r = r_s2;
	assign out_side = side_s2;
endmodule

FILE: test/tb.sv
// Testbench for the horizon/equatorial converter: directed table, random items, latitude changes.
`timescale 1ns / 1ps

module tb;
	import hec_pkg::*;

	localparam int AB = 24;
	localparam int NS = 24;
	localparam int LATENCY = 6 * (NS + 2) + 1;
	localparam int QTR = 1 << (AB - 2);
	// CORDIC residue allowed between a typed-in direction and the predictor
	localparam int TOL = 16;

	// Directed stimulus row; chk marks rows whose result is typed in
	typedef struct {
		logic          func;
		logic [AB-1:0] lon;
		int            lat;
		logic [AB-1:0] lst;
		bit            chk;
		logic [AB-1:0] exp_lon;
		int            exp_lat;
	} dir_row_t;

	typedef struct {
		logic [AB-1:0]        lon;
		logic signed [AB-1:0] lat;
	} dir_t;

	logic clk;
	logic arst_n;

	hec_req_if #(.ANGLE_BITS(AB)) req ();
	hec_rsp_if #(.ANGLE_BITS(AB)) rsp ();
	hec_cfg_if #(.ANGLE_BITS(AB)) cfg ();

	horizon_equatorial_conversion_core #(.ANGLE_BITS(AB), .CORDIC_STAGES(NS)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.cfg(cfg)
	);

	longint atan_q[32];
	longint gain_q31;
	logic [AB-1:0] site_lat;
	dir_t expected_dirs[$];
	dir_t table_dirs[$];
	int errors;
	int n_items;
	int n_checked;
	int send_idle_pct;
	int recv_stall_pct;

	// Clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Watchdog
	initial begin
		#50ms;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic longint floor_shr(longint v, int s);
		return v >>> s;
	endfunction

	// Circular distance between two binary angles
	function automatic int ang_dist(logic [AB-1:0] p, logic [AB-1:0] q);
		logic signed [AB-1:0] d;
		d = p - q;
		return (d < 0) ? -int'(d) : int'(d);
	endfunction

	// atan table and inverse gain computed straight from the series
	function automatic void build_consts();
		longint q;
		longint sum;
		longint r;
		longint bt;
		int i;
		int k;
		atan_q[0] = longint'(1) << 29;
		for (i = 1; i < 32; i++) begin
			sum = 0;
			for (k = 0; i * (2 * k + 1) <= 62; k++) begin
				if (k % 2) sum -= (longint'(1) << (62 - i * (2 * k + 1))) / (2 * k + 1);
				else sum += (longint'(1) << (62 - i * (2 * k + 1))) / (2 * k + 1);
			end
			atan_q[i] = (sum + 64'd6746518852 / 2) / 64'd6746518852;
		end
		q = longint'(1) << 62;
		for (i = 0; i < NS; i++) q -= q / ((longint'(1) << (2 * i)) + 1);
		r = 0;
		bt = longint'(1) << 62;
		while (bt > q) bt >>= 2;
		while (bt != 0) begin
			if (q >= r + bt) begin
				q -= r + bt;
				r = (r >> 1) + bt;
			end else begin
				r >>= 1;
			end
			bt >>= 2;
		end
		gain_q31 = r;
	endfunction

	function automatic longint remove_gain(longint v);
		return floor_shr(v * gain_q31 + (longint'(1) << 30), 31);
	endfunction

	// Rotate pair (a,b) by phase t (full turn 2^32)
	function automatic void cordic_rotate(inout longint a, inout longint b, input logic [31:0] t);
		longint r;
		longint da;
		longint db;
		int i;
		r = longint'(t);
		if (r >= (longint'(1) << 31)) r -= longint'(1) << 32;
		if (r > (longint'(1) << 30)) begin
			a = -a; b = -b; r -= longint'(1) << 31;
		end else if (r < -(longint'(1) << 30)) begin
			a = -a; b = -b; r += longint'(1) << 31;
		end
		for (i = 0; i < NS; i++) begin
			da = floor_shr(b, i);
			db = floor_shr(a, i);
			if (r >= 0) begin
				a -= da; b += db; r -= atan_q[i];
			end else begin
				a += da; b -= db; r += atan_q[i];
			end
		end
		a = remove_gain(a);
		b = remove_gain(b);
	endfunction

	// Angle and magnitude of (a,b)
	function automatic logic [31:0] cordic_vector(input longint a, input longint b,
			output longint mag);
		logic [31:0] acc;
		longint da;
		longint db;
		int i;
		acc = '0;
		if (a == 0 && b == 0) begin
			mag = 0;
			return 32'd0;
		end
		if (a < 0) begin
			a = -a; b = -b; acc = 32'h8000_0000;
		end
		for (i = 0; i < NS; i++) begin
			da = floor_shr(b, i);
			db = floor_shr(a, i);
			if (b >= 0) begin
				a += da; b -= db; acc = acc + 32'(atan_q[i]);
			end else begin
				a -= da; b += db; acc = acc - 32'(atan_q[i]);
			end
		end
		mag = remove_gain(a);
		return acc;
	endfunction

	function automatic dir_t convert_direction(logic func, logic [AB-1:0] lon,
			logic [AB-1:0] lat, logic [AB-1:0] lst);
		logic [31:0] plon;
		logic [31:0] plat;
		logic [31:0] p_lon;
		logic [31:0] p_lat;
		logic [31:0] p_lst;
		logic [31:0] p_site;
		longint x;
		longint y;
		longint z;
		longint rho;
		longint unused;
		longint v;
		longint ol;
		dir_t d;
		p_lon = {lon, 8'd0};
		p_lat = {lat, 8'd0};
		p_lst = {lst, 8'd0};
		p_site = {site_lat, 8'd0};
		x = longint'(1) << 30;
		y = 0;
		z = 0;
		cordic_rotate(x, z, p_lat);
		if (!func) begin
			cordic_rotate(x, y, 32'd0 - p_lon);
			cordic_rotate(z, x, 32'h4000_0000 - p_site);
			cordic_rotate(x, y, p_lst);
		end else begin
			cordic_rotate(x, y, p_lon);
			cordic_rotate(x, y, 32'd0 - p_lst);
			cordic_rotate(z, x, p_site - 32'h4000_0000);
		end
		plon = cordic_vector(x, y, rho);
		if (func) plon = 32'd0 - plon;
		plat = cordic_vector(rho, z, unused);
		ol = (longint'(plon) + 128) >> 8;
		v = longint'(plat);
		if (v >= (longint'(1) << 31)) v -= longint'(1) << 32;
		v = floor_shr(v + 128, 8);
		if (v > QTR) v = QTR;
		if (v < -QTR) v = -QTR;
		d.lon = AB'(ol);
		d.lat = AB'(v);
		return d;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("MISMATCH %s: got %0d expected %0d (item %0d)", what, got, want, n_checked);
		errors++;
	endtask

	// Response sink: random stall, check against oldest expectation
	initial begin
		dir_t e;
		rsp.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp.valid && rsp.ready) begin
				if (expected_dirs.size() == 0) begin
					report_mismatch("unexpected item", 0, 0);
				end else begin
					e = expected_dirs.pop_front();
					if (rsp.out_lon !== e.lon) report_mismatch("out_lon", rsp.out_lon, e.lon);
					if (rsp.out_lat !== e.lat)
						report_mismatch("out_lat", rsp.out_lat, e.lat);
				end
				n_checked++;
			end
			@(negedge clk);
			rsp.ready = ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Leaves valid high after acceptance; the next call idles or drives its own item, the drain lowers it
	task automatic send_direction(logic func, logic [AB-1:0] lon, logic [AB-1:0] lat,
			logic [AB-1:0] lst);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid <= 1'b1;
		req.func <= func;
		req.angle_lon <= lon;
		req.angle_lat <= lat;
		req.sidereal_time <= lst;
		expected_dirs.push_back(convert_direction(func, lon, lat, lst));
		do @(posedge clk); while (!req.ready);
		n_items++;
		@(negedge clk);
	endtask

	task automatic drain_pipeline();
		int guard;
		guard = 0;
		req.valid <= 1'b0;
		while (expected_dirs.size() != 0 && guard < 200000) begin
			@(negedge clk);
			guard++;
		end
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	task automatic write_site_latitude(int value);
		cfg.valid <= 1'b1;
		cfg.data <= AB'(value);
		do @(posedge clk); while (!cfg.ready);
		site_lat = AB'(value);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	function automatic logic [AB-1:0] random_lat();
		case ($urandom_range(5))
			0: return AB'(QTR);
			1: return AB'(-QTR);
			2: return AB'($urandom);
			default: return AB'(int'($urandom_range(2 * QTR)) - QTR);
		endcase
	endfunction

	task automatic random_phase(int count, int idle, int stall);
		int i;
		send_idle_pct = idle;
		recv_stall_pct = stall;
		for (i = 0; i < count; i++)
			send_direction($urandom_range(1), AB'($urandom), random_lat(), AB'($urandom));
	endtask

	dir_row_t rows[$];
	int latitudes[6];
	int j;

	initial begin
		errors = 0;
		n_items = 0;
		n_checked = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		site_lat = '0;
		req.valid = 1'b0;
		req.func = 1'b0;
		req.angle_lon = '0;
		req.angle_lat = '0;
		req.sidereal_time = '0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		arst_n = 1'b0;
		build_consts();
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed table: poles, extremes, both conversions, wrapping lon/lst.
		// With the site on the equator, zenith maps to the meridian on the equator,
		// nadir to the opposite side, and a celestial pole to the horizon.
		rows = '{
			'{1'b0, 24'd0, QTR, 24'd0, 1'b1, 24'd0, 0},
			'{1'b1, 24'd0, QTR, 24'd0, 1'b1, 24'h800000, 0},
			'{1'b0, 24'd0, -QTR, 24'd0, 1'b1, 24'h800000, 0},
			'{1'b1, 24'hABCDEF, -QTR, 24'h123456, 1'b1, 24'd0, 0},
			'{1'b0, 24'd0, 0, 24'd0, 1'b0, 0, 0},
			'{1'b1, 24'd0, 0, 24'd0, 1'b0, 0, 0},
			'{1'b0, 24'hFFFFFF, 0, 24'hFFFFFF, 1'b0, 0, 0},
			'{1'b1, 24'hFFFFFF, 0, 24'hFFFFFF, 1'b0, 0, 0},
			'{1'b0, 24'h400000, 1000, 24'h800000, 1'b0, 0, 0},
			'{1'b1, 24'h800000, -1000, 24'h400000, 1'b0, 0, 0},
			'{1'b0, 24'h555555, 24'h7FFFFF, 24'hAAAAAA, 1'b0, 0, 0},
			'{1'b1, 24'hAAAAAA, -24'h800000, 24'h555555, 1'b0, 0, 0},
			'{1'b0, 24'hC00000, QTR - 1, 24'h000001, 1'b0, 0, 0},
			'{1'b1, 24'h7FFFFF, -QTR + 1, 24'h800000, 1'b0, 0, 0},
			'{1'b0, 24'h123456, 24'h300000, 24'h654321, 1'b0, 0, 0}
		};
		foreach (rows[i]) begin
			send_direction(rows[i].func, rows[i].lon, AB'(rows[i].lat), rows[i].lst);
			if (rows[i].chk) begin
				// Pole rows: predictor must land on the typed-in direction up to CORDIC residue
				table_dirs.push_back(expected_dirs[expected_dirs.size() - 1]);
				if (ang_dist(table_dirs[$].lon, rows[i].exp_lon) > TOL
						|| ang_dist(table_dirs[$].lat, AB'(rows[i].exp_lat)) > TOL)
					report_mismatch("table row", i, 0);
			end
		end
		drain_pipeline();

		// Random phases across latitude settings, extremes included
		latitudes = '{0, QTR, -QTR, 24'h1A2B3C - (1 << 23), 3000000, -1};
		for (j = 0; j < 6; j++) begin
			write_site_latitude(latitudes[j]);
			random_phase(30, 0, 0);
			random_phase(30, 77, 0);
			random_phase(30, 0, 77);
			random_phase(15, 9, 9);
			send_idle_pct = 0;
			recv_stall_pct = 0;
			drain_pipeline();
		end

		$display("Covered %0d items over 6 site latitudes, both conversions, with idle/stall phases.",
			n_items);
		$display("Checked %0d results.", n_checked);
		if (errors == 0 && expected_dirs.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
